/* sv/leb_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// leb_pkg: shared types and constants of the line edit buffer
// Command codes, controller states and the command/status bundles that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package leb_pkg;

	localparam int CAPACITY_DEF = 256;
	localparam int FUNC_W       = 3;
	localparam int CHAR_W       = 8;
	localparam int IDX_W        = 8;
	localparam int RES_W        = 9;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_INSERT    = 3'd0,
		FUNC_BACKSPACE = 3'd1,
		FUNC_CLEAR     = 3'd2,
		FUNC_LEFT      = 3'd3,
		FUNC_RIGHT     = 3'd4,
		FUNC_HOME      = 3'd5,
		FUNC_END       = 3'd6,
		FUNC_READ      = 3'd7
	} func_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_INS_SHIFT,
		ST_INS_DRAIN,
		ST_INS_CHAR,
		ST_BS_SHIFT,
		ST_BS_DRAIN,
		ST_READ
	} state_t;

	typedef struct packed {
		logic latch;
		logic ptr_load_len;
		logic ptr_load_cur;
		logic ins_step;
		logic bs_step;
		logic char_wr;
		logic rd_issue;
		logic finish;
	} ctrl_cmd_t;

	typedef struct packed {
		func_t func;
		logic  full;
		logic  cur_zero;
		logic  ins_done;
		logic  bs_done;
	} dp_status_t;

endpackage

/* sv/leb_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// leb_ctrl: command sequencer of the line edit buffer
// Decodes the latched command and steps the datapath through shifts,
// reads and the final state update.
// ----------------------------------------------------------------------------
module leb_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  leb_pkg::dp_status_t  status,
	output leb_pkg::ctrl_cmd_t   cmd
);

	leb_pkg::state_t state_q;
	leb_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= leb_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			leb_pkg::ST_IDLE: begin
				if (start) begin
					cmd.latch = 1'b1;
					state_d   = leb_pkg::ST_DISPATCH;
				end
			end
			leb_pkg::ST_DISPATCH: begin
				unique case (status.func)
					leb_pkg::FUNC_INSERT: begin
						if (status.full) begin
							cmd.finish = 1'b1;
							state_d    = leb_pkg::ST_IDLE;
						end else begin
							cmd.ptr_load_len = 1'b1;
							state_d          = leb_pkg::ST_INS_SHIFT;
						end
					end
					leb_pkg::FUNC_BACKSPACE: begin
						if (status.cur_zero) begin
							cmd.finish = 1'b1;
							state_d    = leb_pkg::ST_IDLE;
						end else begin
							cmd.ptr_load_cur = 1'b1;
							state_d          = leb_pkg::ST_BS_SHIFT;
						end
					end
					leb_pkg::FUNC_READ: begin
						cmd.rd_issue = 1'b1;
						state_d      = leb_pkg::ST_READ;
					end
					default: begin
						cmd.finish = 1'b1;
						state_d    = leb_pkg::ST_IDLE;
					end
				endcase
			end
			// move words up one place, from the end down to the cursor
			leb_pkg::ST_INS_SHIFT: begin
				if (status.ins_done) begin
					state_d = leb_pkg::ST_INS_DRAIN;
				end else begin
					cmd.ins_step = 1'b1;
				end
			end
			leb_pkg::ST_INS_DRAIN: begin
				state_d = leb_pkg::ST_INS_CHAR;
			end
			leb_pkg::ST_INS_CHAR: begin
				cmd.char_wr = 1'b1;
				cmd.finish  = 1'b1;
				state_d     = leb_pkg::ST_IDLE;
			end
			leb_pkg::ST_BS_SHIFT: begin
				if (status.bs_done) begin
					state_d = leb_pkg::ST_BS_DRAIN;
				end else begin
					cmd.bs_step = 1'b1;
				end
			end
			leb_pkg::ST_BS_DRAIN: begin
				cmd.finish = 1'b1;
				state_d    = leb_pkg::ST_IDLE;
			end
			leb_pkg::ST_READ: begin
				cmd.finish = 1'b1;
				state_d    = leb_pkg::ST_IDLE;
			end
		endcase
	end

	assign busy = (state_q != leb_pkg::ST_IDLE);

endmodule

/* sv/leb_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// leb_datapath: text memory, length, cursor and result registers
// Performs one memory read and one pipelined write per cycle while shifting,
// and updates length and cursor when the controller finishes a command.
// ----------------------------------------------------------------------------
module leb_datapath #(
	parameter int CAPACITY = leb_pkg::CAPACITY_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  leb_pkg::ctrl_cmd_t            cmd,
	output leb_pkg::dp_status_t           status,
	input  logic [leb_pkg::FUNC_W-1:0]    func,
	input  logic [leb_pkg::CHAR_W-1:0]    char_in,
	input  logic [leb_pkg::IDX_W-1:0]     read_index,
	output logic                          done,
	output logic                          ok,
	output logic [leb_pkg::RES_W-1:0]     length,
	output logic [leb_pkg::RES_W-1:0]     cursor,
	output logic [leb_pkg::CHAR_W-1:0]    read_char
);

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int LW = $clog2(CAPACITY + 1);
	localparam int IW = leb_pkg::IDX_W;
	localparam int CW = leb_pkg::CHAR_W;
	localparam int RW = leb_pkg::RES_W;

	logic [CW-1:0] mem [CAPACITY];

	leb_pkg::func_t func_q;
	logic [CW-1:0]  char_q;
	logic [IW-1:0]  ridx_q;

	logic [LW-1:0]  len_q;
	logic [LW-1:0]  cur_q;
	logic [LW-1:0]  ptr_q;
	logic [LW-1:0]  ptr_dec;
	logic [LW-1:0]  cur_dec;

	logic           pend_s1;
	logic [AW-1:0]  waddr_s1;
	logic [CW-1:0]  rdata_q;

	logic           we;
	logic [AW-1:0]  waddr;
	logic [CW-1:0]  wdata;
	logic           rd_en;
	logic [AW-1:0]  raddr;

	logic [IW+AW-1:0] ridx_ext;
	logic [IW+LW-1:0] ridx_cmp;
	logic [IW+LW-1:0] len_cmp;
	logic             in_range;

	logic [LW-1:0]  len_d;
	logic [LW-1:0]  cur_d;
	logic           ok_d;
	logic [CW-1:0]  rchar_d;

	logic [RW+LW-1:0] len_out;
	logic [RW+LW-1:0] cur_out;

	logic          done_q;
	logic          ok_q;
	logic [CW-1:0] rchar_q;

	assign ptr_dec  = ptr_q - LW'(1);
	assign cur_dec  = cur_q - LW'(1);
	assign ridx_ext = {{AW{1'b0}}, ridx_q};
	assign ridx_cmp = {{LW{1'b0}}, ridx_q};
	assign len_cmp  = {{IW{1'b0}}, len_q};
	assign in_range = (ridx_cmp < len_cmp);

	always_comb begin
		status.func     = func_q;
		status.full     = (len_q == LW'(CAPACITY));
		status.cur_zero = (cur_q == '0);
		status.ins_done = (ptr_q == cur_q);
		status.bs_done  = (ptr_q == len_q);
	end

	// command latch
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			func_q <= leb_pkg::FUNC_READ;
			char_q <= '0;
			ridx_q <= '0;
		end else if (cmd.latch) begin
			func_q <= leb_pkg::func_t'(func);
			char_q <= char_in;
			ridx_q <= read_index;
		end
	end

	// memory ports: each shift write follows its read in the next cycle
	assign we    = pend_s1 | cmd.char_wr;
	assign waddr = cmd.char_wr ? cur_q[AW-1:0] : waddr_s1;
	assign wdata = cmd.char_wr ? char_q : rdata_q;
	assign rd_en = cmd.ins_step | cmd.bs_step | cmd.rd_issue;

	always_comb begin
		if (cmd.ins_step) begin
			raddr = ptr_dec[AW-1:0];
		end else if (cmd.bs_step) begin
			raddr = ptr_q[AW-1:0];
		end else begin
			raddr = ridx_ext[AW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (rd_en) begin
			rdata_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ins_step) begin
			waddr_s1 <= ptr_q[AW-1:0];
		end else if (cmd.bs_step) begin
			waddr_s1 <= ptr_dec[AW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_s1 <= 1'b0;
			ptr_q   <= '0;
		end else begin
			pend_s1 <= cmd.ins_step | cmd.bs_step;
			if (cmd.ptr_load_len) begin
				ptr_q <= len_q;
			end else if (cmd.ptr_load_cur) begin
				ptr_q <= cur_q;
			end else if (cmd.ins_step) begin
				ptr_q <= ptr_dec;
			end else if (cmd.bs_step) begin
				ptr_q <= ptr_q + LW'(1);
			end
		end
	end

	// new length, cursor and result of the latched command
	always_comb begin
		len_d   = len_q;
		cur_d   = cur_q;
		ok_d    = 1'b0;
		rchar_d = '0;
		unique case (func_q)
			leb_pkg::FUNC_INSERT: begin
				if (!status.full) begin
					len_d = len_q + LW'(1);
					cur_d = cur_q + LW'(1);
					ok_d  = 1'b1;
				end
			end
			leb_pkg::FUNC_BACKSPACE: begin
				if (!status.cur_zero) begin
					len_d = len_q - LW'(1);
					cur_d = cur_dec;
					ok_d  = 1'b1;
				end
			end
			leb_pkg::FUNC_CLEAR: begin
				len_d = '0;
				cur_d = '0;
				ok_d  = 1'b1;
			end
			leb_pkg::FUNC_LEFT: begin
				if (!status.cur_zero) begin
					cur_d = cur_dec;
					ok_d  = 1'b1;
				end
			end
			leb_pkg::FUNC_RIGHT: begin
				if (cur_q < len_q) begin
					cur_d = cur_q + LW'(1);
					ok_d  = 1'b1;
				end
			end
			leb_pkg::FUNC_HOME: begin
				cur_d = '0;
				ok_d  = 1'b1;
			end
			leb_pkg::FUNC_END: begin
				cur_d = len_q;
				ok_d  = 1'b1;
			end
			leb_pkg::FUNC_READ: begin
				if (in_range) begin
					rchar_d = rdata_q;
					ok_d    = 1'b1;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q  <= '0;
			cur_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.finish;
			if (cmd.finish) begin
				len_q <= len_d;
				cur_q <= cur_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			ok_q    <= ok_d;
			rchar_q <= rchar_d;
		end
	end

	assign len_out   = {{RW{1'b0}}, len_q};
	assign cur_out   = {{RW{1'b0}}, cur_q};
	assign done      = done_q;
	assign ok        = ok_q;
	assign length    = len_out[RW-1:0];
	assign cursor    = cur_out[RW-1:0];
	assign read_char = rchar_q;

	a_cur_le_len: assert property (@(posedge clk) disable iff (!arst_n)
		cur_q <= len_q)
		else $error("cursor beyond length");

	a_len_le_cap: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LW'(CAPACITY))
		else $error("length beyond capacity");

	a_wr_port: assert property (@(posedge clk) disable iff (!arst_n)
		!(pend_s1 && cmd.char_wr))
		else $error("shift write collides with character write");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("result strobe longer than one cycle");

	a_step_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.ins_step && cmd.bs_step) && !(cmd.finish && (cmd.ins_step || cmd.bs_step)))
		else $error("conflicting datapath commands");

endmodule

/* sv/line_edit_buffer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_edit_buffer: one-line text edit buffer with a cursor
// Top level joining the command sequencer and the text datapath.
// ----------------------------------------------------------------------------
// Usage:
//   A command word (func, char_in, read_index) is taken at a rising edge with
//   start high and busy low. Exactly one result word follows: done is high for
//   one cycle with ok, length, cursor and read_char valid in that cycle. The
//   receiver cannot hold results off; done is never stretched.
//   Insert first moves the words behind the cursor (length - cursor) up one
//   place, then writes the character at the cursor; it is refused when full.
//   Backspace moves the words from the cursor on down one place; it is
//   refused at position zero. Read fetches the word at read_index, and the
//   other commands update length and cursor only.
//   The next command can be accepted in the done cycle. Shifts move one word
//   per cycle through the single-write, single-read text memory.
//   Reset clears length and cursor at once; the text memory is not cleared
//   and needs no clearing pass, since only written positions are read.
// ----------------------------------------------------------------------------
module line_edit_buffer #(
	parameter int CAPACITY = leb_pkg::CAPACITY_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [leb_pkg::FUNC_W-1:0]    func,
	input  logic [leb_pkg::CHAR_W-1:0]    char_in,
	input  logic [leb_pkg::IDX_W-1:0]     read_index,
	output logic                          done,
	output logic                          ok,
	output logic [leb_pkg::RES_W-1:0]     length,
	output logic [leb_pkg::RES_W-1:0]     cursor,
	output logic [leb_pkg::CHAR_W-1:0]    read_char
);

	leb_pkg::ctrl_cmd_t  cmd;
	leb_pkg::dp_status_t status;

	leb_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.status (status),
		.cmd    (cmd)
	);

	leb_datapath #(
		.CAPACITY (CAPACITY)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.status     (status),
		.func       (func),
		.char_in    (char_in),
		.read_index (read_index),
		.done       (done),
		.ok         (ok),
		.length     (length),
		.cursor     (cursor),
		.read_char  (read_char)
	);

endmodule
